// ----- src/stok_pkg.sv -----
// Shared types and constants for the source tokenizer.
package stok_pkg;

  localparam int unsigned MaxSourceBytes   = 1048576;
  localparam int unsigned KeywordMaxLength = 8;

  localparam logic [62:0] ValMax = {63{1'b1}};

  // Token kinds
  localparam logic [5:0] KindEnd    = 6'd0;
  localparam logic [5:0] KindIdent  = 6'd1;
  localparam logic [5:0] KindNumber = 6'd2;
  localparam logic [5:0] KindString = 6'd3;
  localparam logic [5:0] KindKwBase = 6'd4;
  localparam logic [5:0] KindPunct  = 6'd16;
  localparam logic [5:0] KindNe     = 6'd30;
  localparam logic [5:0] KindNot    = 6'd31;
  localparam logic [5:0] KindEqEq   = 6'd32;
  localparam logic [5:0] KindAssign = 6'd33;
  localparam logic [5:0] KindLe     = 6'd34;
  localparam logic [5:0] KindLt     = 6'd35;
  localparam logic [5:0] KindGe     = 6'd36;
  localparam logic [5:0] KindGt     = 6'd37;
  localparam logic [5:0] KindSlash  = 6'd28;

  typedef enum logic [2:0] {
    ModeIdle, ModeIdent, ModeNumber, ModeString, ModeEscape, ModeOper, ModeComment
  } scan_mode_e;

  typedef struct packed {
    logic [5:0]  kind;
    logic [19:0] offset;
    logic [19:0] length;
    logic [15:0] line;
    logic [15:0] column;
    logic [62:0] value;
    logic        last;
  } token_t;

  // Keyword text, first byte in the low lane, padded with zero bytes
  typedef logic [7:0][7:0] kw_text_t;
  localparam int unsigned NumKeywords = 12;

  function automatic kw_text_t kw_text(input logic [3:0] idx);
    kw_text_t t;
    t = '0;
    unique case (idx)
      4'd0: t[2:0] = {"w", "e", "n"};
      4'd1: t[5:0] = {"e", "n", "i", "f", "e", "d"};
      4'd2: t[4:0] = {"o", "r", "c", "a", "m"};
      4'd3: t[1:0] = {"n", "f"};
      4'd4: t[5:0] = {"n", "r", "u", "t", "e", "r"};
      4'd5: t[5:0] = {"e", "t", "e", "l", "e", "d"};
      4'd6: t[3:0] = {"e", "e", "r", "f"};
      4'd7: t[5:0] = {"c", "o", "l", "l", "a", "m"};
      4'd8: t[6:0] = {"c", "o", "l", "l", "a", "e", "r"};
      4'd9: t[1:0] = {"f", "i"};
      4'd10: t[3:0] = {"e", "s", "l", "e"};
      4'd11: t[4:0] = {"e", "l", "i", "h", "w"};
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] kw_len(input logic [3:0] idx);
    logic [3:0] l;
    unique case (idx)
      4'd0: l = 4'd3;  4'd1: l = 4'd6;  4'd2: l = 4'd5;  4'd3: l = 4'd2;
      4'd4: l = 4'd6;  4'd5: l = 4'd6;  4'd6: l = 4'd4;  4'd7: l = 4'd6;
      4'd8: l = 4'd7;  4'd9: l = 4'd2;  4'd10: l = 4'd4; 4'd11: l = 4'd5;
      default: l = 4'd0;
    endcase
    return l;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Operator kind for a pending operator byte, one or two characters
  function automatic logic [5:0] oper_kind(input logic [7:0] op, input logic two);
    logic [5:0] k;
    unique case (op)
      "!": k = two ? KindNe : KindNot;
      "=": k = two ? KindEqEq : KindAssign;
      "<": k = two ? KindLe : KindLt;
      ">": k = two ? KindGe : KindGt;
      default: k = KindSlash;
    endcase
    return k;
  endfunction

  // Single-character punctuator lookup; returns hit flag and kind
  function automatic logic [6:0] punct_kind(input logic [7:0] c);
    logic [6:0] r;
    unique case (c)
      "#": r = {1'b1, 6'd16};  "(": r = {1'b1, 6'd17};  ")": r = {1'b1, 6'd18};
      "{": r = {1'b1, 6'd19};  "}": r = {1'b1, 6'd20};  "[": r = {1'b1, 6'd21};
      "]": r = {1'b1, 6'd22};  ",": r = {1'b1, 6'd23};  ";": r = {1'b1, 6'd24};
      "+": r = {1'b1, 6'd25};  "-": r = {1'b1, 6'd26};  "*": r = {1'b1, 6'd27};
      "/": r = {1'b1, 6'd28};  "%": r = {1'b1, 6'd29};
      default: r = {1'b0, KindEnd};
    endcase
    return r;
  endfunction

endpackage

// ----- src/stok_if.sv -----
// Valid/ready stream interfaces for source bytes and tokens.
interface stok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_source;
  modport source (output valid, source_byte, end_of_source, input ready);
  modport sink (input valid, source_byte, end_of_source, output ready);
endinterface

interface stok_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [19:0] token_offset;
  logic [19:0] token_length;
  logic [15:0] token_line;
  logic [15:0] token_column;
  logic [62:0] number_value;
  logic        last_of_run;
  modport source (output valid, token_kind, token_offset, token_length, token_line,
                  token_column, number_value, last_of_run, input ready);
  modport sink (input valid, token_kind, token_offset, token_length, token_line,
                token_column, number_value, last_of_run, output ready);
endinterface

// ----- src/stok_kw_match.sv -----
// Keyword matcher: maps a buffered identifier prefix and length to a token kind.
module stok_kw_match
  import stok_pkg::*;
#(
  parameter int unsigned KwMax = KeywordMaxLength
) (
  input  logic [KwMax-1:0][7:0] prefix_i,
  input  logic [19:0]           length_i,
  output logic [5:0]            kind_o
);

  localparam int unsigned PfxN = (KwMax < 8) ? KwMax : 8;

  kw_text_t pfx8;

  // Only the first eight bytes can matter: no keyword is longer
  always_comb begin
    pfx8 = '0;
    for (int b = 0; b < int'(PfxN); b++) pfx8[b] = prefix_i[b];
  end

  always_comb begin
    kind_o = KindIdent;
    for (int k = NumKeywords - 1; k >= 0; k--) begin
      logic     match;
      kw_text_t kt;
      kt    = kw_text(4'(k));
      match = (length_i == 20'(kw_len(4'(k))));
      for (int b = 0; b < 8; b++) begin
        if (4'(b) < kw_len(4'(k)) && pfx8[b] != kt[b]) match = 1'b0;
      end
      if (match) kind_o = KindKwBase + 6'(k);
    end
  end

endmodule

// ----- src/source_tokenizer_unit.sv -----
// Source tokenizer top level: streaming lexer with a two-entry result buffer.
//
// One source byte is taken per clock. Each byte updates the scanner state and
// may produce up to two tokens (a flushed pending token and a new one),
// which go into a two-word output buffer; the input stalls only while that
// buffer cannot take a further pair, so a byte every cycle is sustained while
// each byte yields at most one token and the sink keeps up, and a byte that
// yields two tokens stalls the input until the first of them has left. The
// buffer is registered, so an accepted byte's first token is offered in the
// cycle after the byte is taken. The second token of a pair leaves after the first.
module source_tokenizer_unit
  import stok_pkg::*;
#(
  parameter int unsigned MAX_SOURCE_BYTES   = MaxSourceBytes,
  parameter int unsigned KEYWORD_MAX_LENGTH = KeywordMaxLength
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  stok_in_if.sink  in_i,
  stok_out_if.source out_o
);

  localparam logic [19:0] PosMax =
    (MAX_SOURCE_BYTES - 1 < 32'hFFFFF) ? 20'(MAX_SOURCE_BYTES - 1) : 20'hFFFFF;
  localparam int unsigned IdxW = $clog2(KEYWORD_MAX_LENGTH);

  // Scanner state
  scan_mode_e  mode_q, mode_d;
  logic [19:0] pos_q, pos_d;
  logic [15:0] line_q, line_d, col_q, col_d;
  logic [19:0] beg_off_q, beg_off_d;
  logic [15:0] beg_line_q, beg_line_d, beg_col_q, beg_col_d;
  logic [62:0] acc_q, acc_d;
  logic [7:0]  op_q, op_d;
  logic [KEYWORD_MAX_LENGTH-1:0][7:0] pfx_q;
  logic        pfx_we;
  logic [IdxW-1:0] pfx_idx;
  logic [7:0]  pfx_wdata;

  // Output buffer (two words)
  token_t      buf_q [2];
  logic [1:0]  cnt_q;
  logic [1:0]  keep;
  token_t      t0, t1;
  logic [1:0]  n_new;

  logic        in_fire, out_fire, eos;
  logic [7:0]  c;
  logic [19:0] cur_len;
  logic [5:0]  ident_k;

  assign c        = in_i.source_byte;
  assign eos      = in_i.end_of_source || (c == 8'd0);
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign in_i.ready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_o.ready);
  assign cur_len  = pos_q - beg_off_q;

  stok_kw_match #(.KwMax(KEYWORD_MAX_LENGTH)) u_kw (
    .prefix_i (pfx_q),
    .length_i (cur_len),
    .kind_o   (ident_k)
  );

  // Next-state and token generation for one byte
  always_comb begin
    token_t flush_t, start_t, here_t;
    logic   have_flush, have_start, do_start;
    logic [6:0] pk;
    logic [66:0] mul;
    logic [3:0]  d;

    mode_d = mode_q;   pos_d = pos_q;   line_d = line_q;   col_d = col_q;
    beg_off_d = beg_off_q; beg_line_d = beg_line_q; beg_col_d = beg_col_q;
    acc_d = acc_q; op_d = op_q;
    pfx_we = 1'b0; pfx_idx = '0; pfx_wdata = c;
    have_flush = 1'b0; have_start = 1'b0; do_start = 1'b0;
    d = c[3:0];
    pk = punct_kind(c);
    // times ten as two shifted copies
    mul = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + 67'(d);

    here_t = '{kind: KindEnd, offset: pos_q, length: 20'd0, line: line_q,
               column: col_q, value: 63'd0, last: 1'b0};
    flush_t = '{kind: KindEnd, offset: beg_off_q, length: cur_len, line: beg_line_q,
                column: beg_col_q, value: 63'd0, last: 1'b0};
    unique case (mode_q)
      ModeIdent:  begin have_flush = 1'b1; flush_t.kind = ident_k; end
      ModeNumber: begin have_flush = 1'b1; flush_t.kind = KindNumber;
                        flush_t.value = acc_q; end
      ModeString, ModeEscape: begin have_flush = 1'b1; flush_t.kind = KindString; end
      ModeOper:   begin have_flush = 1'b1; flush_t.kind = oper_kind(op_q, 1'b0);
                        flush_t.length = 20'd1; end
      default:    have_flush = 1'b0;
    endcase
    start_t = here_t;

    if (eos) begin
      mode_d = ModeIdle; pos_d = '0; line_d = 16'd1; col_d = 16'd1;
      beg_off_d = '0; beg_line_d = 16'd1; beg_col_d = 16'd1; acc_d = '0; op_d = '0;
      have_start = 1'b1;
    end else begin
      unique case (mode_q)
        ModeIdent: begin
          if (is_alpha(c) || is_digit(c)) begin
            have_flush = 1'b0;
            pfx_we  = (cur_len < 20'(KEYWORD_MAX_LENGTH));
            pfx_idx = cur_len[IdxW-1:0];
          end else do_start = 1'b1;
        end
        ModeNumber: begin
          if (is_digit(c)) begin
            have_flush = 1'b0;
            acc_d = (mul > 67'(ValMax)) ? ValMax : mul[62:0];
          end else do_start = 1'b1;
        end
        ModeString: begin
          have_flush = (c == "\"");
          if (c == "\"") mode_d = ModeIdle;
          else if (c == "\\") mode_d = ModeEscape;
        end
        ModeEscape: begin have_flush = 1'b0; mode_d = ModeString; end
        ModeOper: begin
          if (op_q == "/" && c == "/") begin
            have_flush = 1'b0; mode_d = ModeComment;
          end else if (op_q != "/" && c == "=") begin
            flush_t.kind = oper_kind(op_q, 1'b1); flush_t.length = 20'd2;
            mode_d = ModeIdle;
          end else do_start = 1'b1;
        end
        ModeComment: if (c == 8'h0A) mode_d = ModeIdle;
        default: do_start = 1'b1;
      endcase

      // Start of a new token
      if (do_start) begin
        mode_d = ModeIdle;
        priority if (c == " " || c == 8'h0D || c == 8'h09 || c == 8'h0A) begin
          have_start = 1'b0;
        end else if (is_alpha(c)) begin
          beg_off_d = pos_q; beg_line_d = line_q; beg_col_d = col_q;
          pfx_we = 1'b1; pfx_idx = '0; mode_d = ModeIdent;
        end else if (is_digit(c)) begin
          beg_off_d = pos_q; beg_line_d = line_q; beg_col_d = col_q;
          acc_d = 63'(d); mode_d = ModeNumber;
        end else if (c == "\"") begin
          beg_off_d = (pos_q < PosMax) ? pos_q + 20'd1 : PosMax;
          beg_line_d = line_q; beg_col_d = col_q; mode_d = ModeString;
        end else if (c == "/" || c == "!" || c == "=" || c == "<" || c == ">") begin
          beg_off_d = pos_q; beg_line_d = line_q; beg_col_d = col_q;
          op_d = c; mode_d = ModeOper;
        end else if (pk[6]) begin
          have_start = 1'b1; start_t.kind = pk[5:0]; start_t.length = 20'd1;
        end else begin
          have_start = 1'b1;
        end
      end

      // Position, line and column advance
      if (pos_q < PosMax) pos_d = pos_q + 20'd1;
      if (c == 8'h0A) begin
        if (line_q != 16'hFFFF) line_d = line_q + 16'd1;
        col_d = 16'd1;
      end else if (col_q != 16'hFFFF) begin
        col_d = col_q + 16'd1;
      end
    end

    // Pack into first/second result words
    n_new = 2'(have_flush) + 2'(have_start);
    t0 = have_flush ? flush_t : start_t;
    t1 = start_t;
    t0.last = (n_new == 2'd1);
    t1.last = 1'b1;
  end

  // Scanner registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle; pos_q <= '0; line_q <= 16'd1; col_q <= 16'd1;
      beg_off_q <= '0; beg_line_q <= 16'd1; beg_col_q <= 16'd1;
      acc_q <= '0; op_q <= '0;
    end else if (in_fire) begin
      mode_q <= mode_d; pos_q <= pos_d; line_q <= line_d; col_q <= col_d;
      beg_off_q <= beg_off_d; beg_line_q <= beg_line_d; beg_col_q <= beg_col_d;
      acc_q <= acc_d; op_q <= op_d;
    end
  end

  // Identifier prefix store, entries read only after being written
  always_ff @(posedge clk_i) begin
    if (in_fire && !eos && pfx_we) pfx_q[pfx_idx] <= pfx_wdata;
  end

  // Output buffer: pop from the head, push new words behind what remains
  assign keep = cnt_q - 2'(out_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= keep + (in_fire ? n_new : 2'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && keep == 2'd0) begin
      buf_q[0] <= t0;
      buf_q[1] <= t1;
    end else begin
      if (out_fire) buf_q[0] <= buf_q[1];
      if (in_fire) buf_q[1] <= t0;
    end
  end

  assign out_o.valid        = (cnt_q != 2'd0);
  assign out_o.token_kind   = buf_q[0].kind;
  assign out_o.token_offset = buf_q[0].offset;
  assign out_o.token_length = buf_q[0].length;
  assign out_o.token_line   = buf_q[0].line;
  assign out_o.token_column = buf_q[0].column;
  assign out_o.number_value = buf_q[0].value;
  assign out_o.last_of_run  = buf_q[0].last;

`ifndef SYNTHESIS
  // Buffer never exceeds its two words
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("token buffer overflow");
  // Input only taken when room remains for the words it produces
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> keep == 2'd0 || (keep == 2'd1 && n_new != 2'd2))
    else $error("input accepted without buffer space");
  // After an end of source the scanner is back at its start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && eos |=> mode_q == ModeIdle && pos_q == 20'd0 && line_q == 16'd1)
    else $error("scanner not reset after end of source");
`endif

endmodule
